@@ src/gbil_pkg.sv @@
// Shared types for the genomic bin interval lookup.
// Request and response structs, operation and status codes.
// No dependencies.
package gbil_pkg;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STATUS_DONE = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_HIT  = 2'd2,
        STATUS_MISS = 2'd3
    } status_t;

    typedef struct packed {
        func_t       func;
        logic [7:0]  chrom_id;
        logic [31:0] bin_start_in;
        logic [31:0] bin_end_in;
        logic [31:0] coord;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  bin_index;
    } rsp_t;

endpackage

@@ src/gbil_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered. No dependencies.
module gbil_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wen,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/genomic_bin_interval_lookup.sv @@
// Genomic bin lookup: a sorted bin table in two RAMs and the sequencer that searches it.
// Bin fields live in an entry RAM indexed by bin number; an order RAM holds bin numbers
// sorted by (chromosome, start, number). Each search step reads the order RAM, then the
// entry RAM, then compares. An insert then moves each order entry at or above the insertion
// point up one slot, since the order RAM moves one entry per cycle through its single write
// port. Clear, unused and full-table requests skip the search. A stalled response holds the
// block, and the next request can be accepted in the cycle after the response goes out.
// No clearing pass after reset. Depends on gbil_pkg and gbil_ram.
module genomic_bin_interval_lookup
    import gbil_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int CHROM_BITS  = 8,
    parameter int COORD_BITS  = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int ENT_W = CHROM_BITS + 2 * COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_ORD,
        S_ENT,
        S_SHIFT,
        S_RESP
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   is_ins_reg;
    logic [CHROM_BITS-1:0]  ch_reg;
    logic [COORD_BITS-1:0]  key_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic [CNT_W-1:0]       hi_reg;
    logic [CNT_W-1:0]       mid_reg;
    logic [IDX_W-1:0]       eidx_reg;
    logic                   cand_eq_reg;
    logic [COORD_BITS-1:0]  cand_end_reg;
    logic [IDX_W-1:0]       cand_idx_reg;
    logic [CNT_W-1:0]       rdst_reg;
    logic [IDX_W-1:0]       wdst_reg;
    logic                   pend_reg;
    rsp_t                   res_reg;
    rsp_t                   rsp_reg;
    logic                   rsp_valid_reg;

    logic                   req_fire;
    logic                   full;
    logic [CHROM_BITS+7:0]  ch_wide;
    logic [COORD_BITS+31:0] start_wide;
    logic [COORD_BITS+31:0] end_wide;
    logic [COORD_BITS+31:0] coord_wide;
    logic [CHROM_BITS-1:0]  ch_in;
    logic [COORD_BITS-1:0]  start_in;
    logic [COORD_BITS-1:0]  end_in;
    logic [COORD_BITS-1:0]  coord_in;
    logic [CNT_W-1:0]       mid_c;
    logic [CNT_W-1:0]       rdst_dec;
    logic [IDX_W+9:0]       hit_wide;
    logic [IDX_W+9:0]       ins_wide;

    logic                   ord_wen;
    logic [IDX_W-1:0]       ord_waddr;
    logic [IDX_W-1:0]       ord_wdata;
    logic [IDX_W-1:0]       ord_raddr;
    logic [IDX_W-1:0]       ord_rdata;
    logic                   ent_wen;
    logic [ENT_W-1:0]       ent_wdata;
    logic [ENT_W-1:0]       ent_rdata;

    logic [CHROM_BITS-1:0]  e_chrom;
    logic [COORD_BITS-1:0]  e_start;
    logic [COORD_BITS-1:0]  e_end;
    logic                   e_le;

    assign req_fire  = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign full      = (count_reg == CNT_W'(MAX_ENTRIES));

    // Trim incoming fields to the configured chromosome and coordinate widths.
    assign ch_wide    = {{CHROM_BITS{1'b0}}, req.chrom_id};
    assign start_wide = {{COORD_BITS{1'b0}}, req.bin_start_in};
    assign end_wide   = {{COORD_BITS{1'b0}}, req.bin_end_in};
    assign coord_wide = {{COORD_BITS{1'b0}}, req.coord};
    assign ch_in      = ch_wide[CHROM_BITS-1:0];
    assign start_in   = start_wide[COORD_BITS-1:0];
    assign end_in     = end_wide[COORD_BITS-1:0];
    assign coord_in   = coord_wide[COORD_BITS-1:0];

    assign mid_c    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rdst_dec = rdst_reg - CNT_W'(1);
    assign hit_wide = {10'd0, cand_idx_reg};
    assign ins_wide = {10'd0, count_reg[IDX_W-1:0]};

    assign e_chrom = ent_rdata[ENT_W-1 -: CHROM_BITS];
    assign e_start = ent_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign e_end   = ent_rdata[COORD_BITS-1:0];
    assign e_le    = (e_chrom < ch_reg) || ((e_chrom == ch_reg) && (e_start <= key_reg));

    // New bin fields go to the entry RAM at the next free number on accept.
    assign ent_wen   = req_fire && (req.func == FUNC_INSERT) && !full;
    assign ent_wdata = {ch_in, start_in, end_in};

    always_comb
    begin
        ord_wen   = 1'b0;
        ord_waddr = wdst_reg;
        ord_wdata = ord_rdata;
        ord_raddr = mid_c[IDX_W-1:0];
        if (state_reg == S_SHIFT)
        begin
            ord_raddr = rdst_dec[IDX_W-1:0];
            if (pend_reg)
            begin
                ord_wen = 1'b1;
            end
            else if (rdst_reg == lo_reg)
            begin
                ord_wen   = 1'b1;
                ord_waddr = lo_reg[IDX_W-1:0];
                ord_wdata = count_reg[IDX_W-1:0];
            end
        end
    end

    gbil_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (IDX_W)
    ) u_order_ram (
        .clk   (clk),
        .wen   (ord_wen),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .raddr (ord_raddr),
        .rdata (ord_rdata)
    );

    gbil_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (ENT_W)
    ) u_entry_ram (
        .clk   (clk),
        .wen   (ent_wen),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ent_wdata),
        .raddr (ord_rdata),
        .rdata (ent_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            is_ins_reg    <= 1'b0;
            ch_reg        <= '0;
            key_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            eidx_reg      <= '0;
            cand_eq_reg   <= 1'b0;
            cand_end_reg  <= '0;
            cand_idx_reg  <= '0;
            rdst_reg      <= '0;
            wdst_reg      <= '0;
            pend_reg      <= 1'b0;
            res_reg       <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the taken response unless a new one loads this cycle.
            if (rsp_valid_reg && !rsp_stall && (state_reg != S_RESP))
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        ch_reg      <= ch_in;
                        lo_reg      <= '0;
                        hi_reg      <= count_reg;
                        cand_eq_reg <= 1'b0;
                        res_reg     <= '{status: STATUS_DONE, bin_index: '0};
                        unique case (req.func)
                            FUNC_CLEAR:
                            begin
                                count_reg <= '0;
                                state_reg <= S_RESP;
                            end
                            FUNC_INSERT:
                            begin
                                is_ins_reg <= 1'b1;
                                key_reg    <= start_in;
                                if (full)
                                begin
                                    res_reg   <= '{status: STATUS_FULL, bin_index: '0};
                                    state_reg <= S_RESP;
                                end
                                else
                                begin
                                    state_reg <= S_SEARCH;
                                end
                            end
                            FUNC_QUERY:
                            begin
                                is_ins_reg <= 1'b0;
                                key_reg    <= coord_in;
                                state_reg  <= S_SEARCH;
                            end
                            FUNC_NOP:
                            begin
                                state_reg <= S_RESP;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end

                S_SEARCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        mid_reg   <= mid_c;
                        state_reg <= S_ORD;
                    end
                    else if (is_ins_reg)
                    begin
                        rdst_reg  <= count_reg;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        // Only the last bin at or below the key decides the answer.
                        if ((lo_reg != '0) && cand_eq_reg && (key_reg < cand_end_reg))
                        begin
                            res_reg <= '{status: STATUS_HIT, bin_index: hit_wide[9:0]};
                        end
                        else
                        begin
                            res_reg <= '{status: STATUS_MISS, bin_index: '0};
                        end
                        state_reg <= S_RESP;
                    end
                end

                S_ORD:
                begin
                    eidx_reg  <= ord_rdata;
                    state_reg <= S_ENT;
                end

                S_ENT:
                begin
                    if (e_le)
                    begin
                        lo_reg       <= mid_reg + CNT_W'(1);
                        cand_eq_reg  <= (e_chrom == ch_reg);
                        cand_end_reg <= e_end;
                        cand_idx_reg <= eidx_reg;
                    end
                    else
                    begin
                        hi_reg <= mid_reg;
                    end
                    state_reg <= S_SEARCH;
                end

                S_SHIFT:
                begin
                    // Move order entries up one slot, top first, then drop the new bin in.
                    if (rdst_reg > lo_reg)
                    begin
                        pend_reg <= 1'b1;
                        wdst_reg <= rdst_reg[IDX_W-1:0];
                        rdst_reg <= rdst_dec;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            res_reg   <= '{status: STATUS_DONE, bin_index: ins_wide[9:0]};
                            state_reg <= S_RESP;
                        end
                    end
                end

                S_RESP:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("bin count above table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg) && (hi_reg <= count_reg))
        else $error("search bounds out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (rdst_reg >= lo_reg) && (rdst_reg <= count_reg))
        else $error("order shift ran past insertion point");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT && !pend_reg && rdst_reg == lo_reg)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

endmodule

@@ sim/genomic_bin_interval_lookup_tb.sv @@
// Self-checking testbench for genomic_bin_interval_lookup: predicts each response from its own
// bin table and checks responses in order under random request gaps and response stalls.
// Depends on gbil_pkg and the genomic_bin_interval_lookup RTL.
module genomic_bin_interval_lookup_tb;
    import gbil_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        req_t r;
        bit   drain;
    } stim_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    stim_t stim_q [$];
    rsp_t  expected_rsp [$];

    // Bins by arrival index, as the block should hold them
    logic [31:0] bin_lo  [TABLE_DEPTH];
    logic [31:0] bin_hi  [TABLE_DEPTH];
    logic [7:0]  bin_chr [TABLE_DEPTH];
    int bin_count  = 0;
    int peak_count = 0;

    int mismatches  = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_hit       = 0;
    int n_miss      = 0;
    int n_full      = 0;
    int n_done      = 0;
    int cycle_count = 0;

    int gap_left   = 0;
    int calm_tx    = 0;
    int stall_left = 0;
    int calm_rx    = 0;

    genomic_bin_interval_lookup u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #4 clk = ~clk;

    // Apply one request to the bin table and return the response it should produce
    function automatic rsp_t table_step(req_t r);
        rsp_t o;
        int   best;
        o.status    = STATUS_DONE;
        o.bin_index = '0;
        best        = -1;
        case (r.func)
            FUNC_CLEAR: bin_count = 0;
            FUNC_INSERT:
            begin
                if (bin_count == TABLE_DEPTH)
                begin
                    o.status = STATUS_FULL;
                end
                else
                begin
                    bin_lo[bin_count]  = r.bin_start_in;
                    bin_hi[bin_count]  = r.bin_end_in;
                    bin_chr[bin_count] = r.chrom_id;
                    o.bin_index        = 10'(bin_count);
                    bin_count++;
                    if (bin_count > peak_count)
                        peak_count = bin_count;
                end
            end
            FUNC_QUERY:
            begin
                // greatest start at or below coord; later bins win ties
                for (int i = 0; i < bin_count; i++)
                    if (bin_chr[i] == r.chrom_id && bin_lo[i] <= r.coord &&
                        (best < 0 || bin_lo[i] >= bin_lo[best]))
                        best = i;
                o.status = STATUS_MISS;
                if (best >= 0 && r.coord < bin_hi[best])
                begin
                    o.status    = STATUS_HIT;
                    o.bin_index = 10'(best);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic req_t make_req(func_t f, logic [7:0] ch, logic [31:0] lo,
                                      logic [31:0] hi, logic [31:0] co);
        req_t r;
        r.func         = f;
        r.chrom_id     = ch;
        r.bin_start_in = lo;
        r.bin_end_in   = hi;
        r.coord        = co;
        return r;
    endfunction

    function automatic void push_req(req_t r, bit drain);
        stim_t s;
        s.r     = r;
        s.drain = drain;
        stim_q.insert(stim_q.size(), s);
    endfunction

    // Mostly short idle runs, a few long ones
    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 3);
        if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.insert(expected_rsp.size(), table_step(req));
                n_sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (calm_tx > 0)
                    calm_tx--;
                else if ($urandom_range(0, 149) == 0)
                    calm_tx = 50;
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                // hold a draining request until every response is back
                else if (stim_q.size() > 0 && !(stim_q[0].drain && expected_rsp.size() > 0))
                begin
                    req       <= stim_q[0].r;
                    req_valid <= 1'b1;
                    void'(stim_q.pop_front());
                    gap_left = (calm_tx == 0 && $urandom_range(0, 2) == 0) ? draw_idle() : 0;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Response side
    always @(posedge clk or negedge rst_n)
    begin : rsp_side
        rsp_t want;
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d index %0d",
                                 rsp.status, rsp.bin_index);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    n_checked++;
                    case (want.status)
                        STATUS_HIT:  n_hit++;
                        STATUS_MISS: n_miss++;
                        STATUS_FULL: n_full++;
                        default:     n_done++;
                    endcase
                    if (rsp.status !== want.status || rsp.bin_index !== want.bin_index)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"response %0d: expected status %0d index %0d,",
                                      " got status %0d index %0d"},
                                     n_checked, want.status, want.bin_index,
                                     rsp.status, rsp.bin_index);
                    end
                end
            end
            if (calm_rx > 0)
                calm_rx--;
            else if (stall_left == 0 && $urandom_range(0, 99) == 0)
                calm_rx = 60;
            if (stall_left == 0 && calm_rx == 0 && $urandom_range(0, 4) == 0)
                stall_left = draw_idle();
            rsp_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0]  ep_chr [3];
        logic [7:0]  ep_ch [$];
        logic [31:0] ep_lo [$];
        logic [7:0]  ch;
        logic [31:0] base;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] co;
        int          n_random;
        int          ins_left;
        int          q_left;
        int          k;
        int          pick;

        // Directed: field extremes, tie on start, hidden bins, reversed bins, unused func
        push_req(make_req(FUNC_CLEAR,  8'h00, 32'h0, 32'h0, 32'h0), 1'b1);
        push_req(make_req(FUNC_QUERY,  8'h00, 32'h0, 32'h0, 32'h0), 1'b0);
        push_req(make_req(FUNC_NOP,    8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
        push_req(make_req(FUNC_INSERT, 8'h00, 32'h0, 32'hFFFF_FFFF, 32'h0), 1'b0);
        push_req(make_req(FUNC_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'hFF, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h00, 32'h0, 32'h0, 32'h0), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h00, 32'h0, 32'h0, 32'hFFFF_FFFE), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h00, 32'h0, 32'h0, 32'hFFFF_FFFF), 1'b0);
        push_req(make_req(FUNC_INSERT, 8'h05, 32'd1000, 32'd2000, 32'h0), 1'b0);
        push_req(make_req(FUNC_INSERT, 8'h05, 32'd1000, 32'd1500, 32'h0), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h05, 32'h0, 32'h0, 32'd1700), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h05, 32'h0, 32'h0, 32'd1200), 1'b0);
        push_req(make_req(FUNC_INSERT, 8'h05, 32'd1600, 32'd1100, 32'h0), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h05, 32'h0, 32'h0, 32'd1650), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h05, 32'h0, 32'h0, 32'd999), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h06, 32'h0, 32'h0, 32'd1200), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h04, 32'h0, 32'h0, 32'd1200), 1'b0);
        push_req(make_req(FUNC_INSERT, 8'h00, 32'd500, 32'd600, 32'h0), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h00, 32'h0, 32'h0, 32'd550), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h00, 32'h0, 32'h0, 32'd700), 1'b0);
        push_req(make_req(FUNC_CLEAR,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h00, 32'h0, 32'h0, 32'd10), 1'b0);
        push_req(make_req(FUNC_INSERT, 8'h80, 32'h8000_0000, 32'h8000_0001, 32'h0), 1'b0);
        push_req(make_req(FUNC_QUERY,  8'h80, 32'h0, 32'h0, 32'h8000_0000), 1'b0);

        // Random episodes: clear, then inserts and queries mixed on a few chromosomes
        n_random = 0;
        while (n_random < 50)
        begin
            ep_ch.delete();
            ep_lo.delete();
            for (int c = 0; c < 3; c++)
                ep_chr[c] = 8'($urandom());
            base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                               : $urandom();
            ins_left = $urandom_range(1, 40);
            q_left   = $urandom_range(10, 60);
            push_req(make_req(FUNC_CLEAR, 8'($urandom()), $urandom(), $urandom(), $urandom()),
                     1'b1);
            n_random++;
            while (ins_left + q_left > 0)
            begin
                if ($urandom_range(0, 24) == 0)
                begin
                    push_req(make_req(func_t'($urandom_range(0, 3)), 8'($urandom()),
                                      $urandom(), $urandom(), $urandom()), 1'b0);
                end
                else if (ins_left > 0 && (q_left == 0 || $urandom_range(0, 1) == 0))
                begin
                    ch = ep_chr[$urandom_range(0, 2)];
                    if (ep_lo.size() > 0 && $urandom_range(0, 4) == 0)
                        lo = ep_lo[$urandom_range(0, ep_lo.size() - 1)];
                    else
                        lo = base + $urandom_range(0, 4000);
                    case ($urandom_range(0, 9))
                        0:       hi = lo;
                        1:       hi = lo - $urandom_range(1, 100);
                        default: hi = lo + $urandom_range(1, 600);
                    endcase
                    push_req(make_req(FUNC_INSERT, ch, lo, hi, $urandom()), 1'b0);
                    ep_ch.insert(ep_ch.size(), ch);
                    ep_lo.insert(ep_lo.size(), lo);
                    ins_left--;
                end
                else
                begin
                    pick = $urandom_range(0, 19);
                    if (ep_lo.size() > 0 && pick < 14)
                    begin
                        k  = $urandom_range(0, ep_lo.size() - 1);
                        ch = ep_ch[k];
                        co = ep_lo[k] + $urandom_range(0, 700) - 32'd50;
                    end
                    else if (pick < 17)
                    begin
                        ch = ep_chr[$urandom_range(0, 2)];
                        co = base + $urandom_range(0, 4600);
                    end
                    else
                    begin
                        ch = 8'($urandom());
                        co = $urandom();
                    end
                    push_req(make_req(FUNC_QUERY, ch, $urandom(), $urandom(), co), 1'b0);
                    q_left--;
                end
                n_random++;
            end
        end

        // Fill the table in ascending order so no insert has to shift, then overflow it
        ep_ch.delete();
        ep_lo.delete();
        push_req(make_req(FUNC_CLEAR, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1);
        ch = 8'($urandom_range(0, 200));
        lo = $urandom_range(0, 1000);
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (ch < 8'hFF && $urandom_range(0, 49) == 0)
                ch++;
            lo = lo + $urandom_range(0, 3);
            push_req(make_req(FUNC_INSERT, ch, lo, lo + $urandom_range(0, 5), $urandom()),
                     1'b0);
            ep_ch.insert(ep_ch.size(), ch);
            ep_lo.insert(ep_lo.size(), lo);
        end
        for (int i = 0; i < 6; i++)
            push_req(make_req(FUNC_INSERT, 8'($urandom()), $urandom(), $urandom(), $urandom()),
                     1'b0);
        push_req(make_req(FUNC_NOP, 8'($urandom()), $urandom(), $urandom(), $urandom()), 1'b0);
        for (int i = 0; i < 40; i++)
        begin
            k = $urandom_range(0, TABLE_DEPTH - 1);
            push_req(make_req(FUNC_QUERY, ep_ch[k], $urandom(), $urandom(),
                              ep_lo[k] + $urandom_range(0, 6)), 1'b0);
        end
        push_req(make_req(FUNC_CLEAR, 8'($urandom()), $urandom(), $urandom(), $urandom()), 1'b0);
        for (int i = 0; i < 5; i++)
        begin
            k = $urandom_range(0, TABLE_DEPTH - 1);
            push_req(make_req(FUNC_QUERY, ep_ch[k], $urandom(), $urandom(), ep_lo[k]), 1'b0);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (stim_q.size() != 0 || req_valid || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses:", n_sent, n_checked);
        $display("  %0d hits, %0d misses, %0d full, %0d done; table peaked at %0d of %0d",
                 n_hit, n_miss, n_full, n_done, peak_count, TABLE_DEPTH);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
src/gbil_pkg.sv
src/gbil_ram.sv
src/genomic_bin_interval_lookup.sv
sim/genomic_bin_interval_lookup_tb.sv
